/* sv/atc_pkg.sv */
// Shared types, widths and conversion table for the thermistor-to-Celsius block.
package atc_pkg;

  localparam int ADC_W       = 10;
  localparam int TEMP_W      = 16;
  localparam int INTERVAL_W  = 16;
  localparam int COUNT_W     = 7;
  localparam int SUM_W       = 17;
  localparam int UPTIME_W    = 32;
  localparam int DEG_W       = 8;
  localparam int Q_FRAC      = 8;
  localparam int LUT_DEPTH   = 12;
  localparam int SEG_W       = $clog2(LUT_DEPTH);
  localparam int DIFF_W      = ADC_W + 1;
  localparam int DT_W        = DEG_W + 1;
  localparam int PROD_W      = DIFF_W + DT_W;
  localparam int DIV_NUM_W   = 26;
  localparam int DIV_DEN_W   = 10;
  localparam int RES_W       = DIV_NUM_W + 2;

  localparam int SAMPLES_DEF   = 8;
  localparam int TABLE_LEN_DEF = 12;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_SAMPLE_INTERVAL = 1'b0;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 16'd50;
  localparam logic [TEMP_W-1:0]     Q8_MAX         = 16'd57600;

  localparam logic [ADC_W-1:0] LUT_ADC [LUT_DEPTH] = '{
    10'd832, 10'd858, 10'd883, 10'd904, 10'd924, 10'd940,
    10'd955, 10'd968, 10'd977, 10'd987, 10'd994, 10'd999
  };

  localparam logic [DEG_W-1:0] LUT_DEG [LUT_DEPTH] = '{
    8'd65, 8'd60, 8'd55, 8'd50, 8'd45, 8'd40,
    8'd35, 8'd30, 8'd25, 8'd20, 8'd15, 8'd10
  };

  typedef struct packed {
    logic tick;
    logic avg_ld;
    logic conv_ld;
    logic conv_start;
    logic fin;
    logic out_ld;
  } atc_cmd_t;

  typedef struct packed {
    logic avg_pend;
    logic div_done;
    logic out_free;
  } atc_sts_t;

endpackage

/* sv/atc_if.sv */
// Valid/ready channel interfaces for the tick input and the temperature result.
interface atc_in_if;
  logic                      valid;
  logic                      ready;
  logic [atc_pkg::ADC_W-1:0] adc_sample;

  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface atc_out_if;
  logic                       valid;
  logic                       ready;
  logic [atc_pkg::TEMP_W-1:0] temperature_q8;
  logic                       from_average;
  logic [atc_pkg::ADC_W-1:0]  average_raw;

  modport source (output valid, output temperature_q8, output from_average,
                  output average_raw, input ready);
  modport sink   (input valid, input temperature_q8, input from_average,
                  input average_raw, output ready);
endinterface

/* sv/atc_div.sv */
// Iterative unsigned divider, two quotient bits per cycle.
module atc_div #(
  parameter int NUM_W = atc_pkg::DIV_NUM_W,
  parameter int DEN_W = atc_pkg::DIV_DEN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo,
  output logic [DEN_W-1:0] rem
);

  localparam int STEPS = (NUM_W + 1) / 2;
  localparam int PAD_W = 2 * STEPS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] r_r, r_nxt, d_r;
  logic [DEN_W:0]   tmp;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;

  always_comb begin
    q_nxt = q_r;
    r_nxt = r_r;
    tmp   = '0;
    for (int i = 0; i < 2; i++) begin
      tmp   = {r_nxt, q_nxt[PAD_W-1]};
      q_nxt = {q_nxt[PAD_W-2:0], 1'b0};
      if (tmp >= {1'b0, d_r}) begin
        tmp      = tmp - {1'b0, d_r};
        q_nxt[0] = 1'b1;
      end
      r_nxt = tmp[DEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        q_r    <= PAD_W'(num);
        r_r    <= '0;
        d_r    <= den;
        cnt_r  <= CNT_W'(STEPS - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        q_r <= q_nxt;
        r_r <= r_nxt;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = q_r[NUM_W-1:0];
  assign rem  = r_r;

endmodule

/* sv/atc_dp.sv */
// Datapath: tick counters, batch averaging, table interpolation and result register.
module atc_dp #(
  parameter int SAMPLES   = atc_pkg::SAMPLES_DEF,
  parameter int TABLE_LEN = atc_pkg::TABLE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  atc_pkg::atc_cmd_t              cmd,
  output atc_pkg::atc_sts_t              sts,
  input  logic [atc_pkg::ADC_W-1:0]      in_adc,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [atc_pkg::TEMP_W-1:0]     out_temp,
  output logic                           out_from_avg,
  output logic [atc_pkg::ADC_W-1:0]      out_avg_raw,
  input  logic                           cfg_wr,
  input  logic                           cfg_idx,
  input  logic [atc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output logic [atc_pkg::CFG_DATA_W-1:0] cfg_rdata
);

  localparam int ADC_W      = atc_pkg::ADC_W;
  localparam int TEMP_W     = atc_pkg::TEMP_W;
  localparam int INTERVAL_W = atc_pkg::INTERVAL_W;
  localparam int COUNT_W    = atc_pkg::COUNT_W;
  localparam int SUM_W      = atc_pkg::SUM_W;
  localparam int UPTIME_W   = atc_pkg::UPTIME_W;
  localparam int DEG_W      = atc_pkg::DEG_W;
  localparam int SEG_W      = atc_pkg::SEG_W;
  localparam int DIFF_W     = atc_pkg::DIFF_W;
  localparam int DT_W       = atc_pkg::DT_W;
  localparam int PROD_W     = atc_pkg::PROD_W;
  localparam int NUM_W      = atc_pkg::DIV_NUM_W;
  localparam int DEN_W      = atc_pkg::DIV_DEN_W;
  localparam int RES_W      = atc_pkg::RES_W;
  localparam int THR_W      = INTERVAL_W + COUNT_W;
  localparam int AVG_SHIFT  = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W    = SUM_W + 1;
  localparam int AVG_PROD_W = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] AVG_RECIP =
    RECIP_W'(((1 << AVG_SHIFT) + SAMPLES - 1) / SAMPLES);

  logic [INTERVAL_W-1:0] interval_r;
  logic [UPTIME_W-1:0]   uptime_r, uptime_nxt;
  logic [INTERVAL_W-1:0] tss_r, tss_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt, avg_src_r;
  logic [ADC_W-1:0]      batch_avg_r, adc_r;
  logic                  averaged_r, averaged_nxt, avg_pend_r;
  logic                  sample_hit, batch_full;
  logic [THR_W-1:0]      thresh;
  logic [AVG_PROD_W-1:0] avg_prod;

  always_comb begin
    uptime_nxt   = (uptime_r == '1) ? uptime_r : uptime_r + 1'b1;
    tss_nxt      = (tss_r == '1) ? tss_r : tss_r + 1'b1;
    sample_hit   = tss_nxt >= interval_r;
    sum_nxt      = sum_r + SUM_W'(in_adc);
    cnt_nxt      = cnt_r + 1'b1;
    batch_full   = sample_hit && (cnt_nxt >= COUNT_W'(SAMPLES));
    thresh       = THR_W'(interval_r) * THR_W'(SAMPLES);
    averaged_nxt = uptime_nxt > UPTIME_W'(thresh);
  end

  assign avg_prod = AVG_PROD_W'(avg_src_r) * AVG_PROD_W'(AVG_RECIP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= atc_pkg::INTERVAL_RESET;
      uptime_r    <= '0;
      tss_r       <= '0;
      cnt_r       <= '0;
      sum_r       <= '0;
      batch_avg_r <= '0;
      averaged_r  <= 1'b0;
      avg_pend_r  <= 1'b0;
    end else begin
      if (cfg_wr && cfg_idx == atc_pkg::REG_SAMPLE_INTERVAL) begin
        interval_r <= cfg_wdata[INTERVAL_W-1:0];
      end
      if (cmd.tick) begin
        uptime_r   <= uptime_nxt;
        averaged_r <= averaged_nxt;
        avg_pend_r <= batch_full;
        if (sample_hit) begin
          tss_r <= '0;
          if (batch_full) begin
            sum_r <= '0;
            cnt_r <= '0;
          end else begin
            sum_r <= sum_nxt;
            cnt_r <= cnt_nxt;
          end
        end else begin
          tss_r <= tss_nxt;
        end
      end
      if (cmd.avg_ld) begin
        batch_avg_r <= avg_prod[AVG_SHIFT +: ADC_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      adc_r     <= in_adc;
      avg_src_r <= sum_nxt;
    end
  end

  // Segment search and slope product
  logic [ADC_W-1:0]         src;
  logic [SEG_W-1:0]         seg, lo;
  logic                     found;
  logic signed [DIFF_W-1:0] den_s, diff_s;
  logic signed [DT_W-1:0]   dt_s;
  logic signed [PROD_W-1:0] prod_s;
  logic [PROD_W-1:0]        prod_mag;

  always_comb begin
    src   = averaged_r ? batch_avg_r : adc_r;
    found = 1'b0;
    seg   = SEG_W'(1);
    for (int k = TABLE_LEN - 1; k >= 1; k--) begin
      if (atc_pkg::LUT_ADC[k] > src) begin
        found = 1'b1;
        seg   = SEG_W'(k);
      end
    end
    lo       = seg - 1'b1;
    den_s    = $signed({1'b0, atc_pkg::LUT_ADC[seg]}) - $signed({1'b0, atc_pkg::LUT_ADC[lo]});
    dt_s     = $signed({1'b0, atc_pkg::LUT_DEG[seg]}) - $signed({1'b0, atc_pkg::LUT_DEG[lo]});
    diff_s   = $signed({1'b0, src}) - $signed({1'b0, atc_pkg::LUT_ADC[lo]});
    prod_s   = diff_s * dt_s;
    prod_mag = prod_s[PROD_W-1] ? PROD_W'(-prod_s) : PROD_W'(prod_s);
  end

  logic             bypass_r, neg_r;
  logic [DEG_W-1:0] t0_r;
  logic [NUM_W-1:0] mag_r;
  logic [DEN_W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (cmd.conv_ld) begin
      bypass_r <= !found || den_s[DIFF_W-1] || (den_s == '0);
      t0_r     <= found ? atc_pkg::LUT_DEG[lo] : atc_pkg::LUT_DEG[TABLE_LEN-1];
      neg_r    <= prod_s[PROD_W-1];
      mag_r    <= NUM_W'(prod_mag) << atc_pkg::Q_FRAC;
      den_r    <= den_s[DEN_W-1:0];
    end
  end

  // Interpolation divider
  logic             div_start, div_done;
  logic [NUM_W-1:0] div_num, div_quo;
  logic [DEN_W-1:0] div_den, div_rem;

  assign div_start = cmd.conv_start;
  assign div_num   = mag_r;
  assign div_den   = den_r;

  atc_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Floor correction, offset and clamp
  logic [NUM_W:0]          q_adj;
  logic signed [RES_W-1:0] q_s, base_s, res_s;
  logic [TEMP_W-1:0]       res_clamp;

  always_comb begin
    q_adj  = {1'b0, div_quo} + (NUM_W+1)'(neg_r && (div_rem != '0));
    q_s    = neg_r ? -$signed(RES_W'(q_adj)) : $signed(RES_W'(q_adj));
    base_s = $signed(RES_W'({t0_r, {atc_pkg::Q_FRAC{1'b0}}}));
    res_s  = bypass_r ? base_s : base_s + q_s;
    if (res_s < 0) begin
      res_clamp = '0;
    end else if (res_s > $signed(RES_W'(atc_pkg::Q8_MAX))) begin
      res_clamp = atc_pkg::Q8_MAX;
    end else begin
      res_clamp = res_s[TEMP_W-1:0];
    end
  end

  logic [TEMP_W-1:0] res_r, temp_r;
  logic [ADC_W-1:0]  avg_out_r;
  logic              from_avg_r, out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      res_r <= res_clamp;
    end
    if (cmd.out_ld) begin
      temp_r     <= res_r;
      from_avg_r <= averaged_r;
      avg_out_r  <= batch_avg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign sts.avg_pend = avg_pend_r;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid    = out_valid_r;
  assign out_temp     = temp_r;
  assign out_from_avg = from_avg_r;
  assign out_avg_raw  = avg_out_r;

  assign cfg_rdata = (cfg_idx == atc_pkg::REG_SAMPLE_INTERVAL) ?
                     atc_pkg::CFG_DATA_W'(interval_r) : '0;

endmodule

/* sv/atc_ctrl.sv */
// Controller state machine sequencing tick update, averaging and conversion.
module atc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  atc_pkg::atc_sts_t sts,
  output atc_pkg::atc_cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHK    = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIVW   = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.tick  = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        cmd.avg_ld = sts.avg_pend;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.conv_ld = 1'b1;
        state_nxt   = S_DSTART;
      end
      S_DSTART: begin
        cmd.conv_start = 1'b1;
        state_nxt      = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          cmd.fin   = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

/* sv/averaged_thermistor_to_celsius_core.sv */
// Top level: averaged thermistor reading to Q8.8 Celsius converter.
//
//   channel  | dir | fields                                          | transfer
//   in_if    | in  | adc_sample                                      | valid & ready
//   out_if   | out | temperature_q8, from_average, average_raw       | valid & ready
//   APB      | in  | sample_interval at byte 0                       | psel & penable & pwrite
//
// One tick at a time: each input transfer passes through the check, multiply, divider
// start, divider wait and output states before the next is taken. The divider yields two
// bits per cycle; the batch mean is a reciprocal multiply in the check state.
// A new tick is taken while the previous result still waits in the output register;
// a further result holds the controller until that register frees.
// rst_n is synchronous; all counters, the stored average and the interval reset.
module averaged_thermistor_to_celsius_core #(
  parameter int SAMPLES   = atc_pkg::SAMPLES_DEF,
  parameter int TABLE_LEN = atc_pkg::TABLE_LEN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  atc_in_if.sink                         in_if,
  atc_out_if.source                      out_if,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [atc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [atc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [atc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  atc_pkg::atc_cmd_t cmd;
  atc_pkg::atc_sts_t sts;
  logic              in_ready;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  atc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  atc_dp #(.SAMPLES(SAMPLES), .TABLE_LEN(TABLE_LEN)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_adc       (in_if.adc_sample),
    .out_valid    (out_if.valid),
    .out_ready    (out_if.ready),
    .out_temp     (out_if.temperature_q8),
    .out_from_avg (out_if.from_average),
    .out_avg_raw  (out_if.average_raw),
    .cfg_wr       (cfg_wr),
    .cfg_idx      (paddr[2]),
    .cfg_wdata    (pwdata),
    .cfg_rdata    (prdata)
  );

  assign in_if.ready = in_ready;

  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("controller issued more than one command");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_ld |-> sts.out_free)
    else $error("pending result overwritten");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.tick |=> !in_if.ready)
    else $error("tick accepted while previous tick in progress");

  a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> !in_if.ready)
    else $error("ready before result was loaded");

endmodule
